### src/mgmq_pkg.sv
`default_nettype none
package mgmq_pkg;

    localparam int TableEntriesDefault = 16;
    localparam int NumPortsDefault     = 3;
    localparam int QueueDepth          = 2;

    localparam logic [2:0] CfgMembershipInterval = 3'd0;
    localparam logic [2:0] CfgLastMemberTime     = 3'd1;
    localparam logic [2:0] CfgLastMemberInterval = 3'd2;
    localparam logic [2:0] CfgLastMemberCount    = 3'd3;
    localparam logic [2:0] CfgStartupCount       = 3'd4;
    localparam logic [2:0] CfgStartupInterval    = 3'd5;
    localparam logic [2:0] CfgQueryInterval      = 3'd6;

    localparam logic [1:0] EvGeneral  = 2'd0;
    localparam logic [1:0] EvSpecific = 2'd1;
    localparam logic [1:0] EvExpired  = 2'd2;

    localparam logic [2:0] RecIsEx = 3'd2;
    localparam logic [2:0] RecToEx = 3'd4;

    typedef struct packed {
        logic        func;
        logic [1:0]  port;
        logic [31:0] group_address;
        logic [2:0]  record_kind;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [1:0]  out_port;
        logic [31:0] out_group;
        logic        final_res;
    } out_item_t;

    // classified command between front and back
    typedef struct packed {
        logic        is_tick;
        logic        is_exclude;
        logic [1:0]  port;
        logic [31:0] group;
    } cmd_t;

    typedef struct packed {
        logic [15:0] membership_interval;
        logic [15:0] last_member_time;
        logic [15:0] last_member_interval;
        logic [7:0]  last_member_count;
        logic [7:0]  startup_count;
        logic [15:0] startup_interval;
        logic [15:0] query_interval;
    } cfg_t;

endpackage
`default_nettype wire

### src/multicast_group_membership_querier_unit.sv
// a record walks the whole table in the match search, one table entry per cycle, and a tick
//   walks every entry once more, with an extra expiry state per expiry result
// the table walk is sequential: a new transaction is taken only once the last one is finished
// a two-entry queue decouples input from the walk; output is a single result register
// reset: asynchronous active low; table empty, registers at defaults, first tick queries
`default_nettype none
module multicast_group_membership_querier_unit
    import mgmq_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int NUM_PORTS     = NumPortsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_valid, q_ready;
    cmd_t q_data;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{membership_interval: 16'd2600, last_member_time: 16'd20,
                         last_member_interval: 16'd10, last_member_count: 8'd2,
                         startup_count: 8'd2, startup_interval: 16'd312,
                         query_interval: 16'd1250};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgMembershipInterval: cfg_reg.membership_interval  <= cfg_data;
                CfgLastMemberTime:     cfg_reg.last_member_time     <= cfg_data;
                CfgLastMemberInterval: cfg_reg.last_member_interval <= cfg_data;
                CfgLastMemberCount:    cfg_reg.last_member_count    <= cfg_data[7:0];
                CfgStartupCount:       cfg_reg.startup_count        <= cfg_data[7:0];
                CfgStartupInterval:    cfg_reg.startup_interval     <= cfg_data;
                CfgQueryInterval:      cfg_reg.query_interval       <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: filters and classifies each transaction
    mgmq_front #(.NUM_PORTS(NUM_PORTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    // back: walks the table and emits results
    mgmq_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

### src/mgmq_front.sv
`default_nettype none
module mgmq_front
    import mgmq_pkg::*;
#(
    parameter int NUM_PORTS = NumPortsDefault
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output cmd_t          q_data
);

    localparam int PtrW = $clog2(QueueDepth);

    cmd_t               mem_reg [QueueDepth];
    logic [PtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]      count_reg;
    logic               keep;
    logic               push, pop;
    cmd_t               cmd;

    // classify each item and drop records that cause nothing
    always_comb
    begin
        cmd.is_tick    = ~in_data.func;
        cmd.is_exclude = (in_data.record_kind == RecIsEx) || (in_data.record_kind == RecToEx);
        cmd.port       = in_data.port;
        cmd.group      = in_data.group_address;
        keep = ~in_data.func
            || ((in_data.group_address[31:28] == 4'hE)
                && ({28'd0, in_data.port} < 32'(NUM_PORTS))
                && (in_data.record_kind != 3'd0) && (in_data.record_kind != 3'd7));
    end

    assign in_ready = (count_reg != (PtrW+1)'(QueueDepth));
    assign q_valid  = (count_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready && keep;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PtrW'((32'(wr_ptr_reg) + 1) % QueueDepth);
            end
            if (pop)
            begin
                rd_ptr_reg <= PtrW'((32'(rd_ptr_reg) + 1) % QueueDepth);
            end
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PtrW+1)'(QueueDepth))
        else $error("queue overflow");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (PtrW+1)'(QueueDepth)) |-> !push)
        else $error("push into full queue");
    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

### src/mgmq_back.sv
`default_nettype none
module mgmq_back
    import mgmq_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      q_valid,
    output logic           q_ready,
    input  wire cmd_t      q_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_GEN    = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_EXP    = 6'b001000,
        ST_SEARCH = 6'b010000,
        ST_REC    = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CntW-1:0]    idx_reg;
    logic [IdxW-1:0]    idx;
    logic [IdxW-1:0]    slot_reg;
    logic               found_reg, free_found_reg;
    logic [IdxW-1:0]    free_reg;
    cmd_t               cmd_reg;
    logic [15:0]        general_wait_reg;
    logic [7:0]         startup_left_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, excl_reg;
    logic [7:0]         qleft_reg [TABLE_ENTRIES];
    logic [1:0]         port_reg  [TABLE_ENTRIES];
    logic [31:0]        group_reg [TABLE_ENTRIES];
    logic [15:0]        timer_reg [TABLE_ENTRIES];
    logic [15:0]        qwait_reg [TABLE_ENTRIES];

    // output register
    logic               ov_reg;
    out_item_t          od_reg;

    logic               out_free;
    logic               last_entry;
    logic               emit;
    logic [7:0]         lmc;
    logic               any_left;
    logic               any_all;
    logic [TABLE_ENTRIES-1:0] will_emit;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_free  = !ov_reg || out_ready;
    assign idx       = idx_reg[IdxW-1:0];
    assign last_entry = (idx_reg == CntW'(TABLE_ENTRIES - 1));
    assign lmc       = (cfg.last_member_count == 8'd0) ? 8'd1 : cfg.last_member_count;
    assign q_ready   = (state_reg == ST_IDLE);

    // entries that give a result on this tick, and whether any lies beyond idx
    always_comb
    begin
        any_left = 1'b0;
        any_all  = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            will_emit[i] = valid_reg[i]
                && (((qleft_reg[i] > 8'd1) && (qwait_reg[i] <= 16'd1))
                    || (timer_reg[i] <= 16'd1));
            if (will_emit[i])
            begin
                any_all = 1'b1;
                if (CntW'(i) > idx_reg)
                begin
                    any_left = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            cmd_reg <= q_data;
        end
        if (state_reg == ST_SEARCH && !found_reg && free_found_reg)
        begin
            port_reg[free_reg]  <= cmd_reg.port;
            group_reg[free_reg] <= cmd_reg.group;
        end
        if (state_reg == ST_SCAN && out_free && valid_reg[idx])
        begin
            if (qleft_reg[idx] != 8'd0)
            begin
                if (qwait_reg[idx] <= 16'd1)
                begin
                    qwait_reg[idx] <= cfg.last_member_interval;
                end
                else
                begin
                    qwait_reg[idx] <= qwait_reg[idx] - 16'd1;
                end
            end
            if (timer_reg[idx] > 16'd1)
            begin
                timer_reg[idx] <= timer_reg[idx] - 16'd1;
            end
        end
        if (state_reg == ST_REC)
        begin
            if (cmd_reg.is_exclude || !found_reg)
            begin
                timer_reg[slot_reg] <= cfg.membership_interval;
            end
            if (!cmd_reg.is_exclude && (excl_reg[slot_reg] && found_reg))
            begin
                timer_reg[slot_reg] <= cfg.last_member_time;
                if (qleft_reg[slot_reg] == 8'd0)
                begin
                    qwait_reg[slot_reg] <= cfg.last_member_interval;
                end
            end
        end
    end

    // combinational next state and emit decision for every state
    always_comb
    begin
        emit      = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_data.is_tick ? ST_GEN : ST_SEARCH;
                end
            end
            ST_GEN:
            begin
                if (out_free)
                begin
                    emit       = (general_wait_reg <= 16'd1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    emit = valid_reg[idx] && (qleft_reg[idx] > 8'd1)
                        && (qwait_reg[idx] <= 16'd1);
                    state_next = last_entry ? ST_IDLE : ST_SCAN;
                    if (valid_reg[idx] && timer_reg[idx] <= 16'd1)
                    begin
                        state_next = ST_EXP;
                    end
                end
            end
            ST_EXP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = last_entry ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SEARCH:
            begin
                if (idx_reg == CntW'(TABLE_ENTRIES))
                begin
                    state_next = (found_reg || free_found_reg) ? ST_REC : ST_IDLE;
                end
            end
            ST_REC:
            begin
                if (out_free)
                begin
                    emit = !cmd_reg.is_exclude && excl_reg[slot_reg] && found_reg
                        && (qleft_reg[slot_reg] == 8'd0);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            slot_reg         <= '0;
            free_reg         <= '0;
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            general_wait_reg <= 16'd1;
            startup_left_reg <= 8'd2;
            valid_reg        <= '0;
            excl_reg         <= '0;
            ov_reg           <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                qleft_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= emit || (ov_reg && !out_ready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg        <= '0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                ST_GEN:
                begin
                    if (out_free)
                    begin
                        if (general_wait_reg <= 16'd1)
                        begin
                            od_reg <= '{event_kind: EvGeneral, out_port: 2'd0,
                                        out_group: 32'd0, final_res: !any_all};
                            if (startup_left_reg != 8'd0)
                            begin
                                startup_left_reg <= startup_left_reg - 8'd1;
                                general_wait_reg <= cfg.startup_interval;
                            end
                            else
                            begin
                                general_wait_reg <= cfg.query_interval;
                            end
                        end
                        else
                        begin
                            general_wait_reg <= general_wait_reg - 16'd1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (out_free)
                    begin
                        if (valid_reg[idx])
                        begin
                            if (qleft_reg[idx] != 8'd0 && qwait_reg[idx] <= 16'd1)
                            begin
                                qleft_reg[idx] <= qleft_reg[idx] - 8'd1;
                                if (qleft_reg[idx] != 8'd1)
                                begin
                                    od_reg <= '{event_kind: EvSpecific,
                                                out_port: port_reg[idx],
                                                out_group: group_reg[idx],
                                                final_res: (timer_reg[idx] > 16'd1)
                                                           && !any_left};
                                end
                            end
                        end
                        if (!(valid_reg[idx] && timer_reg[idx] <= 16'd1))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_EXP:
                begin
                    if (out_free)
                    begin
                        od_reg <= '{event_kind: EvExpired, out_port: port_reg[idx],
                                    out_group: group_reg[idx], final_res: !any_left};
                        valid_reg[idx] <= 1'b0;
                        excl_reg[idx]  <= 1'b0;
                        qleft_reg[idx] <= 8'd0;
                        idx_reg        <= idx_reg + 1'b1;
                    end
                end
                ST_SEARCH:
                begin
                    if (idx_reg != CntW'(TABLE_ENTRIES))
                    begin
                        if (!found_reg && valid_reg[idx] && port_reg[idx] == cmd_reg.port
                            && group_reg[idx] == cmd_reg.group)
                        begin
                            found_reg <= 1'b1;
                            slot_reg  <= idx;
                        end
                        if (!free_found_reg && !valid_reg[idx])
                        begin
                            free_found_reg <= 1'b1;
                            free_reg       <= idx;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!found_reg && free_found_reg)
                    begin
                        slot_reg            <= free_reg;
                        valid_reg[free_reg] <= 1'b1;
                        excl_reg[free_reg]  <= 1'b0;
                        qleft_reg[free_reg] <= 8'd0;
                    end
                end
                ST_REC:
                begin
                    if (out_free)
                    begin
                        if (cmd_reg.is_exclude)
                        begin
                            excl_reg[slot_reg] <= 1'b1;
                        end
                        else if (excl_reg[slot_reg] && found_reg
                                 && qleft_reg[slot_reg] == 8'd0)
                        begin
                            qleft_reg[slot_reg] <= lmc;
                            od_reg <= '{event_kind: EvSpecific, out_port: cmd_reg.port,
                                        out_group: cmd_reg.group, final_res: 1'b1};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_exp_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP) |-> valid_reg[idx])
        else $error("expiry on free entry");
    a_rec_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REC) |-> valid_reg[slot_reg])
        else $error("record on free entry");

endmodule
`default_nettype wire
